// ----- hw/rtl/levg_pkg.sv -----
// ----------------------------------------------------------------------------
// levg_pkg: shared types and constants of the Lehmer exponential variate unit
// Field widths, the minimal standard LCG constants, the fixed log2 of the
// modulus bound and the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package levg_pkg;

  localparam int SEED_W     = 31;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LOG_W      = 37;  // 5 integer bits, 32 fraction bits
  localparam int CNT_W      = 5;

  localparam logic [14:0]       LCG_MULT = 15'd16807;
  localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [31:0]       LN2_Q32  = 32'hB172_17F8;
  localparam logic [63:0]       RND_HALF = 64'h0000_0000_8000_0000;

  localparam logic [SEED_W-1:0] SEED_RST = 31'd1;
  localparam logic [VAL_W-1:0]  MEAN_RST = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARRIVAL_SEED = 2'd0,
    CFG_SESSION_SEED = 2'd1,
    CFG_ARRIVAL_MEAN = 2'd2,
    CFG_SESSION_MEAN = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_REDUCE,
    ST_NORM,
    ST_SQR,
    ST_DIFF,
    ST_LN_LO,
    ST_LN_HI,
    ST_LN_SUM,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_SUM
  } state_t;

  // Elaboration-time log2 in Q.32: leading one position, then 32 truncated
  // squarings of the Q1.31 mantissa.
  function automatic logic [LOG_W-1:0] log2_q32_f(input logic [31:0] v);
    logic [4:0]  k;
    logic [63:0] m;
    logic [31:0] frac;
    k    = 5'd0;
    frac = 32'd0;
    for (int i = 1; i < 32; i++) begin
      if ((v >> i) != 32'd0) begin
        k = i[4:0];
      end
    end
    m = 64'(v) << (5'd31 - k);
    for (int j = 0; j < 32; j++) begin
      m    = (m * m) >> 31;
      frac = {frac[30:0], m[32]};
      if (m[32]) begin
        m = m >> 1;
      end
    end
    return {k, frac};
  endfunction

  // log2(2 * modulus), the upper bound of every sample
  localparam logic [LOG_W-1:0] LOG2_TOP = log2_q32_f(32'hFFFF_FFFE);

endpackage

`default_nettype wire

// ----- hw/rtl/levg_if.sv -----
// ----------------------------------------------------------------------------
// levg_if: request and result channels of the Lehmer exponential variate unit
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface levg_in_if;
  logic valid;
  logic ready;
  logic stream;

  modport source (output valid, output stream, input ready);
  modport sink   (input valid, input stream, output ready);
endinterface

interface levg_out_if;
  logic                           valid;
  logic                           ready;
  logic [levg_pkg::SEED_W-1:0]    uniform_value;
  logic [levg_pkg::VAL_W-1:0]     exp_value;
  logic                           saturated;

  modport source (output valid, output uniform_value, output exp_value,
                  output saturated, input ready);
  modport sink   (input valid, input uniform_value, input exp_value,
                  input saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lehmer_exponential_variate_gen_unit.sv -----
// One request is in flight at a time: a new request is taken only in the idle state,
// and the 32 mantissa squarings on the single shared 32x32 multiplier take most of the
// time spent on each request.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, rst_n low): both stream seeds to 1, both means to 1.0 (Q16.16),
// sequencer idle, output channel empty.
// ----------------------------------------------------------------------------
// lehmer_exponential_variate_gen_unit: two-stream Park-Miller LCG with
// exponential variates by inversion
// A request names a stream; its seed advances by seed*16807 mod (2^31-1), and
// mean * -ln((seed+0.5)/(2^31-1)) is returned in saturating unsigned Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module lehmer_exponential_variate_gen_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [levg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [levg_pkg::CFG_DATA_W-1:0]     cfg_data,
  levg_in_if.sink                                  in_ch,
  levg_out_if.source                               out_ch
);

  import levg_pkg::*;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r;           // normalise step / squaring count
  logic                sel_r;           // stream of the request in flight
  logic [SEED_W-1:0]   stream_seed_r [2];
  logic [VAL_W-1:0]    arrival_mean_r;
  logic [VAL_W-1:0]    session_mean_r;
  logic [SEED_W-1:0]   seed_r;          // new seed, returned as the uniform sample
  logic [31:0]         m_r;             // mantissa, Q1.31 once normalised
  logic [4:0]          shift_r;         // total normalising shift (31 - leading one)
  logic [31:0]         frac_r;          // log2 fraction bits, MSB first
  logic [63:0]         prod_r;          // registered multiplier output
  logic [31:0]         acc_r;           // rounded upper half of a low partial product
  logic [LOG_W-1:0]    d_r;             // -log2(u), Q.32
  logic [LOG_W-1:0]    l_r;             // -ln(u), Q.32
  logic                out_valid_r;
  logic [SEED_W-1:0]   out_uniform_r;
  logic [VAL_W-1:0]    out_exp_r;
  logic                out_sat_r;

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  logic        in_ready;
  logic        load_out;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [VAL_W-1:0] mean_sel;

  assign mean_sel = sel_r ? session_mean_r : arrival_mean_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_SEED_MUL: state_nxt = ST_REDUCE;
      ST_REDUCE:   state_nxt = ST_NORM;
      ST_NORM: begin
        if (cnt_r == CNT_W'(4)) begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (cnt_r == '1) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF:   state_nxt = ST_LN_LO;
      ST_LN_LO:  state_nxt = ST_LN_HI;
      ST_LN_HI:  state_nxt = ST_LN_SUM;
      ST_LN_SUM: state_nxt = ST_SC_LO;
      ST_SC_LO:  state_nxt = ST_SC_HI;
      ST_SC_HI:  state_nxt = ST_SC_SUM;
      ST_SC_SUM: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operand selection and handshake
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    mul_a    = 32'd0;
    mul_b    = 32'd0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_SEED_MUL: begin
        mul_a = {1'b0, stream_seed_r[sel_r]};
        mul_b = 32'(LCG_MULT);
      end
      ST_SQR: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      ST_LN_LO: begin
        mul_a = d_r[31:0];
        mul_b = LN2_Q32;
      end
      ST_LN_HI: begin
        mul_a = 32'(d_r[LOG_W-1:32]);
        mul_b = LN2_Q32;
      end
      ST_SC_LO: begin
        mul_a = mean_sel;
        mul_b = l_r[31:0];
      end
      ST_SC_HI: begin
        mul_a = mean_sel;
        mul_b = 32'(l_r[LOG_W-1:32]);
      end
      ST_SC_SUM: load_out = !out_valid_r || out_ch.ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The one shared multiplier
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  // Mersenne fold: hi*2^31 + lo == hi + lo (mod 2^31-1), one subtract at most
  logic [31:0]       fold_sum;
  logic [SEED_W-1:0] seed_new;
  assign fold_sum = 32'(prod_r[45:31]) + 32'(prod_r[30:0]);
  assign seed_new = (fold_sum >= 32'(LCG_MOD)) ? SEED_W'(fold_sum - 32'(LCG_MOD))
                                               : fold_sum[SEED_W-1:0];

  // Binary-search normalise: 16, 8, 4, 2, 1 bit steps
  logic        norm_hit;
  logic [31:0] norm_shl;
  logic [4:0]  norm_amt;
  always_comb begin
    case (cnt_r[2:0])
      3'd0: begin
        norm_hit = (m_r[31:16] == 16'd0);
        norm_shl = {m_r[15:0], 16'd0};
        norm_amt = 5'd16;
      end
      3'd1: begin
        norm_hit = (m_r[31:24] == 8'd0);
        norm_shl = {m_r[23:0], 8'd0};
        norm_amt = 5'd8;
      end
      3'd2: begin
        norm_hit = (m_r[31:28] == 4'd0);
        norm_shl = {m_r[27:0], 4'd0};
        norm_amt = 5'd4;
      end
      3'd3: begin
        norm_hit = (m_r[31:30] == 2'd0);
        norm_shl = {m_r[29:0], 2'd0};
        norm_amt = 5'd2;
      end
      default: begin
        norm_hit = !m_r[31];
        norm_shl = {m_r[30:0], 1'b0};
        norm_amt = 5'd1;
      end
    endcase
  end

  // Squaring step: drop 31 bits, renormalise by one when the square reaches 2.0
  logic [32:0] sq_t;
  logic [31:0] m_sq;
  assign sq_t = mul_p[63:31];
  assign m_sq = sq_t[32] ? sq_t[32:1] : sq_t[31:0];

  logic [LOG_W-1:0] log_low;
  assign log_low = {5'd31 - shift_r, frac_r};

  logic [31:0] rnd_hi;
  logic [63:0] rnd_sum;
  assign rnd_sum = prod_r + RND_HALF;
  assign rnd_hi  = rnd_sum[63:32];

  logic [LOG_W:0] res_sum;
  logic           res_sat;
  assign res_sum = (LOG_W+1)'(prod_r[LOG_W-1:0]) + (LOG_W+1)'(acc_r);
  assign res_sat = |res_sum[LOG_W:32];

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_REDUCE: cnt_r <= '0;
        ST_NORM: begin
          if (cnt_r == CNT_W'(4)) begin
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_SQR:  cnt_r <= cnt_r + CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stream seeds and means: configuration writes, seed update per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_seed_r[0] <= SEED_RST;
      stream_seed_r[1] <= SEED_RST;
      arrival_mean_r   <= MEAN_RST;
      session_mean_r   <= MEAN_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ARRIVAL_SEED: stream_seed_r[0] <= cfg_data[SEED_W-1:0];
          CFG_SESSION_SEED: stream_seed_r[1] <= cfg_data[SEED_W-1:0];
          CFG_ARRIVAL_MEAN: arrival_mean_r   <= cfg_data[VAL_W-1:0];
          CFG_SESSION_MEAN: session_mean_r   <= cfg_data[VAL_W-1:0];
          default: begin
            arrival_mean_r <= arrival_mean_r;
          end
        endcase
      end else if (state_r == ST_REDUCE) begin
        stream_seed_r[sel_r] <= seed_new;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          sel_r <= in_ch.stream;
        end
      end
      ST_SEED_MUL: prod_r <= mul_p;
      ST_REDUCE: begin
        seed_r  <= seed_new;
        m_r     <= {seed_new, 1'b1};   // 2*seed + 1, always odd
        shift_r <= 5'd0;
        frac_r  <= 32'd0;
      end
      ST_NORM: begin
        if (norm_hit) begin
          m_r     <= norm_shl;
          shift_r <= shift_r + norm_amt;
        end
      end
      ST_SQR: begin
        m_r    <= m_sq;
        frac_r <= {frac_r[30:0], sq_t[32]};
      end
      ST_DIFF: begin
        // clamp at zero when the sample sits at the top of the range
        d_r <= (LOG2_TOP > log_low) ? (LOG2_TOP - log_low) : '0;
      end
      ST_LN_LO: prod_r <= mul_p;
      ST_LN_HI: begin
        acc_r  <= rnd_hi;
        prod_r <= mul_p;
      end
      ST_LN_SUM: l_r <= prod_r[LOG_W-1:0] + LOG_W'(acc_r);
      ST_SC_LO:  prod_r <= mul_p;
      ST_SC_HI: begin
        acc_r  <= rnd_hi;
        prod_r <= mul_p;
      end
      ST_SC_SUM: begin
        if (load_out) begin
          out_uniform_r <= seed_r;
          out_exp_r     <= res_sat ? '1 : res_sum[31:0];
          out_sat_r     <= res_sat;
        end
      end
      default: begin
        m_r <= m_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.uniform_value = out_uniform_r;
  assign out_ch.exp_value     = out_exp_r;
  assign out_ch.saturated     = out_sat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_seed_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REDUCE |=> seed_r != LCG_MOD)
    else $error("seed left unreduced after the Mersenne fold");

  a_mant_normalised: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQR |-> m_r[31])
    else $error("mantissa lost normalisation during squaring");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_SC_SUM))
    else $error("result appeared outside the final scaling step");

  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> out_exp_r == '1)
    else $error("saturated result not clipped to full scale");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready |=> !in_ready && state_r == ST_SEED_MUL)
    else $error("request transfer did not start the sequencer");

endmodule

`default_nettype wire
